// File: hdl/assert_macros.svh
// Assertion helpers shared by the decimal-adjust unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge, outside of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checks an implication on every rising edge, outside of reset.
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Checks that a condition is followed by another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: hdl/x86bcd_pkg.sv
package x86bcd_pkg;

    // Operation codes.
    localparam logic [2:0] FUNC_DAA = 3'd0;
    localparam logic [2:0] FUNC_DAS = 3'd1;
    localparam logic [2:0] FUNC_AAA = 3'd2;
    localparam logic [2:0] FUNC_AAS = 3'd3;
    localparam logic [2:0] FUNC_AAM = 3'd4;
    localparam logic [2:0] FUNC_AAD = 3'd5;

    // The AAM divide is spread over several stages.
    localparam int DIV_BITS            = 8;
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES          = DIV_BITS / DIV_STEPS_PER_STAGE;

    // Pre stage, divide stages and the flag stage.
    localparam int NUM_STAGES = DIV_STAGES + 2;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] ax_in;
        logic        carry_in;
        logic        aux_carry_in;
        logic [7:0]  base_imm;
    } t_in_word;

    typedef struct packed {
        logic        status;
        logic [15:0] ax_out;
        logic        carry_out;
        logic        parity_out;
        logic        aux_carry_out;
        logic        zero_out;
        logic        sign_out;
        logic        overflow_out;
    } t_out_word;

    // Word in flight between the pre stage and the flag stage.
    typedef struct packed {
        logic [2:0] func;
        logic [7:0] ah;
        logic [7:0] al;
        logic [7:0] flag_al;
        logic       cf;
        logic       af;
        logic       of;
        logic       sf;
        logic [7:0] prod;
        logic [7:0] d_rem;
        logic [7:0] d_quo;
        logic [7:0] d_base;
    } t_pipe;

    // Even parity of a byte: one when the count of set bits is even.
    function automatic logic even_parity8(input logic [7:0] v);
        even_parity8 = ~(^v);
    endfunction

endpackage

// File: hdl/x86_bcd_adjust_unit.sv
// Decimal-adjust unit for the x86 DAA, DAS, AAA, AAS, AAM and AAD instructions.
// Each input word carries the operation, AX, the incoming CF and AF flags and the
// immediate base; each output word returns the new AX, all six arithmetic flags
// and a status bit that flags a divide error when AAM is given a zero base (AX
// is then returned unchanged with all flags clear). Operation codes six and
// seven pass AX, CF and AF through and clear the other flags. The unit is a
// six-stage pipeline: a decode stage that performs the BCD corrections and the
// 8-by-8 multiply for AAD, four stages of restoring division for AAM that each
// produce two quotient bits, and a stage that forms the flags into the output
// register. A new word is accepted in every cycle as long as the output side
// keeps taking results. A stall holds a full output stage and each full stage
// that has only full stages after it, while the other stages keep moving, so
// no word is lost or repeated. Both channels use valid and stall: a word moves
// at an edge where valid is high and stall is low.

`include "assert_macros.svh"

module x86_bcd_adjust_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  x86bcd_pkg::t_in_word   i_word,
    output logic                   o_valid,
    input  logic                   i_stall,
    output x86bcd_pkg::t_out_word  o_word
);

    localparam int LAST = x86bcd_pkg::NUM_STAGES - 1;

    // One valid bit per stage, and the advance enable of each stage.
    logic [LAST:0] r_valid;
    logic [LAST:0] stage_en;

    // Stage outputs between the decode stage and the flag stage.
    x86bcd_pkg::t_pipe pipe [0:x86bcd_pkg::DIV_STAGES];

    // A full decode stage that cannot move on in this cycle.
    logic       pre_held;
    // An output word that reports a divide error.
    logic       div_err;
    // The six arithmetic flags of the output word.
    logic [5:0] out_flags;

    // A stage may load when it is empty or when its content moves on.
    always_comb begin
        stage_en[LAST] = !r_valid[LAST] || !i_stall;
        for (int k = LAST - 1; k >= 0; k--) begin
            stage_en[k] = !r_valid[k] || stage_en[k + 1];
        end
    end

    assign o_stall = !stage_en[0];
    assign o_valid = r_valid[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (stage_en[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (stage_en[k]) begin
                    r_valid[k] <= r_valid[k - 1];
                end
            end
        end
    end

    // Decode stage: BCD corrections and the AAD product.
    x86bcd_pre u_pre (
        .i_clk  (i_clk),
        .i_en   (stage_en[0]),
        .i_word (i_word),
        .o_pipe (pipe[0])
    );

    // Divide stages for AAM.
    for (genvar g = 0; g < x86bcd_pkg::DIV_STAGES; g++) begin : g_div
        x86bcd_div u_div (
            .i_clk  (i_clk),
            .i_en   (stage_en[g + 1]),
            .i_pipe (pipe[g]),
            .o_pipe (pipe[g + 1])
        );
    end

    // Flag stage, which is also the output register.
    x86bcd_flags u_flags (
        .i_clk  (i_clk),
        .i_en   (stage_en[LAST]),
        .i_pipe (pipe[x86bcd_pkg::DIV_STAGES]),
        .o_word (o_word)
    );

    assign pre_held  = r_valid[0] && !stage_en[1];
    assign div_err   = o_valid && o_word.status;
    assign out_flags = {o_word.carry_out, o_word.parity_out, o_word.aux_carry_out,
                        o_word.zero_out, o_word.sign_out, o_word.overflow_out};

    // The input side is only held off when every stage holds a word.
    `ASSERT_IMPL(a_stall_full, i_clk, i_rst_n, o_stall, &r_valid, "stall with an empty stage")

    // A full decode stage that cannot move keeps its word.
    `ASSERT_NEXT(a_pre_valid, i_clk, i_rst_n, pre_held, r_valid[0], "decode stage lost its word")
    `ASSERT_NEXT(a_pre_data, i_clk, i_rst_n, pre_held, $stable(pipe[0]), "decode word changed")

    // A divide error result carries no flags.
    `ASSERT_IMPL(a_err_flags, i_clk, i_rst_n, div_err, !(|out_flags), "flags set on divide error")

endmodule

// File: hdl/x86bcd_pre.sv
module x86bcd_pre (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  x86bcd_pkg::t_in_word  i_word,
    output x86bcd_pkg::t_pipe     o_pipe
);

    x86bcd_pkg::t_pipe r_pipe;
    x86bcd_pkg::t_pipe n_pipe;

    always_comb begin
        logic [7:0]  al;
        logic [7:0]  ah;
        logic        sub;
        logic        low_adj;
        logic        hi_adj;
        logic [8:0]  sum1;
        logic [7:0]  a1;
        logic        cf1;
        logic [7:0]  a2;
        logic [7:0]  la;
        logic [7:0]  lb;
        logic [7:0]  lr;
        logic [15:0] a16;
        logic [15:0] prod_full;

        al        = i_word.ax_in[7:0];
        ah        = i_word.ax_in[15:8];
        sub       = (i_word.func == x86bcd_pkg::FUNC_DAS) ||
                    (i_word.func == x86bcd_pkg::FUNC_AAS);
        low_adj   = (al[3:0] > 4'd9) || i_word.aux_carry_in;
        hi_adj    = (al > 8'h99) || i_word.carry_in;
        sum1      = sub ? ({1'b0, al} - 9'd6) : ({1'b0, al} + 9'd6);
        a1        = low_adj ? sum1[7:0] : al;
        cf1       = low_adj & (i_word.carry_in | sum1[8]);
        a2        = sub ? (a1 - 8'h60) : (a1 + 8'h60);
        la        = hi_adj ? a1 : al;
        lb        = hi_adj ? 8'h60 : 8'h06;
        lr        = hi_adj ? a2 : a1;
        a16       = sub ? (i_word.ax_in - 16'd6) : (i_word.ax_in + 16'd6);
        prod_full = 16'(ah * i_word.base_imm);

        n_pipe         = '0;
        n_pipe.func    = i_word.func;
        n_pipe.ah      = ah;
        n_pipe.al      = al;
        n_pipe.flag_al = al;
        n_pipe.prod    = prod_full[7:0];
        n_pipe.d_rem   = '0;
        n_pipe.d_quo   = al;
        n_pipe.d_base  = i_word.base_imm;

        case (i_word.func)
            x86bcd_pkg::FUNC_DAA, x86bcd_pkg::FUNC_DAS: begin
                n_pipe.al = hi_adj ? a2 : a1;
                n_pipe.cf = hi_adj | (sub & cf1);
                n_pipe.af = low_adj;
                if (hi_adj || low_adj) begin
                    if (sub) begin
                        n_pipe.of = ((la ^ lb) & (la ^ lr) & 8'h80) != 8'h00;
                    end else begin
                        n_pipe.of = ((la ^ lr) & (lb ^ lr) & 8'h80) != 8'h00;
                    end
                end
            end
            x86bcd_pkg::FUNC_AAA, x86bcd_pkg::FUNC_AAS: begin
                if (low_adj) begin
                    n_pipe.ah = a16[15:8] + (sub ? 8'hFF : 8'h01);
                    n_pipe.al = a16[7:0];
                    n_pipe.af = 1'b1;
                    n_pipe.cf = 1'b1;
                end
                n_pipe.flag_al = n_pipe.al;
                n_pipe.sf      = n_pipe.ah[7];
                n_pipe.al      = n_pipe.al & 8'h0F;
            end
            x86bcd_pkg::FUNC_AAM, x86bcd_pkg::FUNC_AAD: begin
                // Finished in the divide stages and the flag stage.
            end
            default: begin
                n_pipe.cf = i_word.carry_in;
                n_pipe.af = i_word.aux_carry_in;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_pipe = r_pipe;

endmodule

// File: hdl/x86bcd_div.sv
module x86bcd_div (
    input  logic               i_clk,
    input  logic               i_en,
    input  x86bcd_pkg::t_pipe  i_pipe,
    output x86bcd_pkg::t_pipe  o_pipe
);

    x86bcd_pkg::t_pipe r_pipe;
    x86bcd_pkg::t_pipe n_pipe;

    // Restoring division, a few quotient bits per stage. The remainder stays
    // below the divisor, so the shifted partial remainder fits in nine bits.
    always_comb begin
        logic [8:0] rem_sh;
        logic [7:0] rem;
        logic [7:0] quo;

        rem = i_pipe.d_rem;
        quo = i_pipe.d_quo;
        for (int k = 0; k < x86bcd_pkg::DIV_STEPS_PER_STAGE; k++) begin
            rem_sh = {rem, quo[7]};
            quo    = {quo[6:0], 1'b0};
            if (rem_sh >= {1'b0, i_pipe.d_base}) begin
                rem_sh = rem_sh - {1'b0, i_pipe.d_base};
                quo[0] = 1'b1;
            end
            rem = rem_sh[7:0];
        end

        n_pipe       = i_pipe;
        n_pipe.d_rem = rem;
        n_pipe.d_quo = quo;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_pipe = r_pipe;

endmodule

// File: hdl/x86bcd_flags.sv
module x86bcd_flags (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  x86bcd_pkg::t_pipe      i_pipe,
    output x86bcd_pkg::t_out_word  o_word
);

    x86bcd_pkg::t_out_word r_word;
    x86bcd_pkg::t_out_word n_word;

    always_comb begin
        logic [8:0] sum9;
        logic [4:0] low5;

        sum9 = {1'b0, i_pipe.al} + {1'b0, i_pipe.prod};
        low5 = {1'b0, i_pipe.al[3:0]} + {1'b0, i_pipe.prod[3:0]};

        n_word        = '0;
        n_word.ax_out = {i_pipe.ah, i_pipe.al};

        case (i_pipe.func)
            x86bcd_pkg::FUNC_DAA, x86bcd_pkg::FUNC_DAS: begin
                n_word.carry_out     = i_pipe.cf;
                n_word.aux_carry_out = i_pipe.af;
                n_word.overflow_out  = i_pipe.of;
                n_word.parity_out    = x86bcd_pkg::even_parity8(i_pipe.al);
                n_word.zero_out      = i_pipe.al == 8'h00;
                n_word.sign_out      = i_pipe.al[7];
            end
            x86bcd_pkg::FUNC_AAA, x86bcd_pkg::FUNC_AAS: begin
                n_word.carry_out     = i_pipe.cf;
                n_word.aux_carry_out = i_pipe.af;
                n_word.parity_out    = x86bcd_pkg::even_parity8(i_pipe.flag_al);
                n_word.zero_out      = i_pipe.flag_al == 8'h00;
                n_word.sign_out      = i_pipe.sf;
            end
            x86bcd_pkg::FUNC_AAM: begin
                if (i_pipe.d_base == 8'h00) begin
                    n_word.status = 1'b1;
                end else begin
                    n_word.ax_out     = {i_pipe.d_quo, i_pipe.d_rem};
                    n_word.parity_out = x86bcd_pkg::even_parity8(i_pipe.d_rem);
                    n_word.zero_out   = i_pipe.d_rem == 8'h00;
                    n_word.sign_out   = i_pipe.d_rem[7];
                end
            end
            x86bcd_pkg::FUNC_AAD: begin
                n_word.ax_out        = {8'h00, sum9[7:0]};
                n_word.carry_out     = sum9[8];
                n_word.aux_carry_out = low5[4];
                n_word.overflow_out  = ((i_pipe.al ^ sum9[7:0]) &
                                        (i_pipe.prod ^ sum9[7:0]) & 8'h80) != 8'h00;
                n_word.parity_out    = x86bcd_pkg::even_parity8(sum9[7:0]);
                n_word.zero_out      = sum9[7:0] == 8'h00;
                n_word.sign_out      = sum9[7];
            end
            default: begin
                n_word.carry_out     = i_pipe.cf;
                n_word.aux_carry_out = i_pipe.af;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

// File: verif/x86_bcd_adjust_unit_tb.sv
`timescale 1ns / 1ps

// Testbench for the x86 decimal-adjust unit. Words are driven on the falling
// edge and both handshakes are observed on the rising edge. Every accepted
// input word is run through a local model of the six decimal-adjust
// instructions, and the predicted output word is queued. Each output word
// the unit delivers is compared field by field against the oldest queued
// prediction.
module x86_bcd_adjust_unit_tb;

    // Codes six and seven have no instruction behind them and act as a no-op.
    localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

    localparam int CLK_HALF    = 5;
    localparam int RESET_TICKS = 8;
    // The pipeline is six stages deep, so SETTLE leaves room for any stragglers.
    localparam int SETTLE      = 12;
    // Even with every pause at its longest, a run stays well below this limit.
    localparam int CYCLE_LIMIT = 1000000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    x86bcd_pkg::t_in_word  i_word;
    logic                  o_valid;
    logic                  i_stall;
    x86bcd_pkg::t_out_word o_word;

    // Predicted output words, oldest first.
    x86bcd_pkg::t_out_word adjusted_q[$];

    int  cycles;
    int  mismatches;
    int  words_sent;
    int  words_checked;
    int  div_errors_seen;
    int  func_count[8];
    // When clear, neither side starts a new bubble or stall.
    bit  idle_on;
    int  rx_hold;

    x86_bcd_adjust_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    always begin
        i_clk = 1'b1;
        #CLK_HALF;
        i_clk = 1'b0;
        #CLK_HALF;
    end

    // Computes the architectural result of one decimal-adjust instruction,
    // including the fixed choices for the flags the architecture leaves open.
    function automatic x86bcd_pkg::t_out_word decimal_adjust(input x86bcd_pkg::t_in_word w);
        x86bcd_pkg::t_out_word r;
        logic [7:0]  al;
        logic [7:0]  ah;
        logic [7:0]  old_al;
        logic [7:0]  la;
        logic [7:0]  lb;
        logic [7:0]  lr;
        logic [7:0]  addend;
        logic [15:0] prod;
        logic [15:0] a16;
        logic [8:0]  sum;
        logic [4:0]  nib_sum;
        logic        sub;
        logic        adj;
        logic        c;
        r      = '0;
        al     = w.ax_in[7:0];
        ah     = w.ax_in[15:8];
        la     = '0;
        lb     = '0;
        lr     = '0;
        adj    = 1'b0;
        case (w.func)
            x86bcd_pkg::FUNC_DAA, x86bcd_pkg::FUNC_DAS: begin
                sub    = (w.func == x86bcd_pkg::FUNC_DAS);
                old_al = al;
                // Low-digit correction by six.
                if (al[3:0] > 4'd9 || w.aux_carry_in) begin
                    c  = sub ? (al < 8'd6) : (al > 8'hF9);
                    la = al;
                    lb = 8'd6;
                    al = sub ? al - 8'd6 : al + 8'd6;
                    lr = al;
                    adj = 1'b1;
                    r.carry_out     = w.carry_in | c;
                    r.aux_carry_out = 1'b1;
                end
                // High-digit correction by 0x60, tested on the original AL.
                if (old_al > 8'h99 || w.carry_in) begin
                    la = al;
                    lb = 8'h60;
                    al = sub ? al - 8'h60 : al + 8'h60;
                    lr = al;
                    adj = 1'b1;
                    r.carry_out = 1'b1;
                end else if (!sub) begin
                    r.carry_out = 1'b0;
                end
                // OF reflects only the last correction that was applied.
                if (adj) begin
                    if (sub)
                        r.overflow_out = (la[7] ^ lb[7]) & (la[7] ^ lr[7]);
                    else
                        r.overflow_out = (la[7] ^ lr[7]) & (lb[7] ^ lr[7]);
                end
                r.parity_out = ~(^al);
                r.zero_out   = (al == 8'h00);
                r.sign_out   = al[7];
                r.ax_out     = {ah, al};
            end
            x86bcd_pkg::FUNC_AAA, x86bcd_pkg::FUNC_AAS: begin
                sub = (w.func == x86bcd_pkg::FUNC_AAS);
                if (al[3:0] > 4'd9 || w.aux_carry_in) begin
                    a16 = sub ? w.ax_in - 16'd6 : w.ax_in + 16'd6;
                    ah  = a16[15:8] + (sub ? 8'hFF : 8'h01);
                    al  = a16[7:0];
                    r.aux_carry_out = 1'b1;
                    r.carry_out     = 1'b1;
                end
                // ZF and PF look at AL before its high nibble is cleared.
                r.parity_out = ~(^al);
                r.zero_out   = (al == 8'h00);
                r.sign_out   = ah[7];
                r.ax_out     = {ah, 4'h0, al[3:0]};
            end
            x86bcd_pkg::FUNC_AAM: begin
                if (w.base_imm == 8'h00) begin
                    r.status = 1'b1;
                    r.ax_out = w.ax_in;
                end else begin
                    ah = al / w.base_imm;
                    al = al % w.base_imm;
                    r.parity_out = ~(^al);
                    r.zero_out   = (al == 8'h00);
                    r.sign_out   = al[7];
                    r.ax_out     = {ah, al};
                end
            end
            x86bcd_pkg::FUNC_AAD: begin
                prod    = ah * w.base_imm;
                addend  = prod[7:0];
                sum     = {1'b0, al} + {1'b0, addend};
                nib_sum = {1'b0, al[3:0]} + {1'b0, addend[3:0]};
                r.carry_out     = sum[8];
                r.aux_carry_out = nib_sum[4];
                r.overflow_out  = (al[7] ^ sum[7]) & (addend[7] ^ sum[7]);
                r.parity_out    = ~(^sum[7:0]);
                r.zero_out      = (sum[7:0] == 8'h00);
                r.sign_out      = sum[7];
                r.ax_out        = {8'h00, sum[7:0]};
            end
            default: begin
                r.ax_out        = w.ax_in;
                r.carry_out     = w.carry_in;
                r.aux_carry_out = w.aux_carry_in;
            end
        endcase
        return r;
    endfunction

    function automatic x86bcd_pkg::t_in_word make_word(input logic [2:0] func,
                                                       input logic [15:0] ax,
                                                       input logic cf, input logic af,
                                                       input logic [7:0] base);
        x86bcd_pkg::t_in_word w;
        w.func         = func;
        w.ax_in        = ax;
        w.carry_in     = cf;
        w.aux_carry_in = af;
        w.base_imm     = base;
        return w;
    endfunction

    // Mostly short pauses, with the occasional long one.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(20, 60);
    endfunction

    // Sends one word. Called on a falling edge, returns on a falling edge.
    // The expectation is queued at the rising edge where the word is taken.
    task automatic send_word(input x86bcd_pkg::t_in_word w);
        if (idle_on && $urandom_range(0, 2) == 0) begin
            i_valid <= 1'b0;
            repeat (pause_len()) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        adjusted_q.push_back(decimal_adjust(w));
        words_sent++;
        func_count[w.func]++;
        if (w.func == x86bcd_pkg::FUNC_AAM && w.base_imm == 8'h00)
            div_errors_seen++;
        @(negedge i_clk);
    endtask

    // Holds off until every queued prediction has been matched.
    task automatic wait_until_empty();
        while (adjusted_q.size() != 0)
            @(negedge i_clk);
    endtask

    // The receiver stalls in bursts of random length while idling is enabled.
    always @(negedge i_clk) begin
        if (rx_hold == 0 && idle_on && $urandom_range(0, 3) == 0)
            rx_hold = pause_len();
        if (rx_hold > 0) begin
            i_stall <= 1'b1;
            rx_hold--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic check_word(input x86bcd_pkg::t_out_word exp,
                              input x86bcd_pkg::t_out_word got);
        if (got.status !== exp.status) begin
            $error("status: expected %0b, got %0b", exp.status, got.status);
            mismatches++;
        end
        if (got.ax_out !== exp.ax_out) begin
            $error("ax_out: expected %h, got %h", exp.ax_out, got.ax_out);
            mismatches++;
        end
        if (got.carry_out !== exp.carry_out) begin
            $error("carry_out: expected %0b, got %0b", exp.carry_out, got.carry_out);
            mismatches++;
        end
        if (got.parity_out !== exp.parity_out) begin
            $error("parity_out: expected %0b, got %0b", exp.parity_out, got.parity_out);
            mismatches++;
        end
        if (got.aux_carry_out !== exp.aux_carry_out) begin
            $error("aux_carry_out: expected %0b, got %0b",
                   exp.aux_carry_out, got.aux_carry_out);
            mismatches++;
        end
        if (got.zero_out !== exp.zero_out) begin
            $error("zero_out: expected %0b, got %0b", exp.zero_out, got.zero_out);
            mismatches++;
        end
        if (got.sign_out !== exp.sign_out) begin
            $error("sign_out: expected %0b, got %0b", exp.sign_out, got.sign_out);
            mismatches++;
        end
        if (got.overflow_out !== exp.overflow_out) begin
            $error("overflow_out: expected %0b, got %0b",
                   exp.overflow_out, got.overflow_out);
            mismatches++;
        end
    endtask

    // Every output word taken by the receiver is matched against the oldest
    // prediction. The cycle counter also guards against a hung pipeline.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still awaited",
                     cycles, adjusted_q.size());
            $display("end of test: mismatches");
            $finish;
        end else if (i_rst_n && o_valid && !i_stall) begin
            if (adjusted_q.size() == 0) begin
                $error("output word %h arrived with nothing awaited", o_word);
                mismatches++;
            end else begin
                check_word(adjusted_q.pop_front(), o_word);
                words_checked++;
            end
        end
    end

    // Packed BCD corrections: no correction, the low-digit correction alone,
    // both at once, a borrow out of the low digit, and the subtract case where CF
    // stays clear because neither correction applies.
    task automatic test_bcd_add_sub_adjust();
        send_word(make_word(x86bcd_pkg::FUNC_DAA, 16'h0000, 1'b0, 1'b0, 8'd10));
        send_word(make_word(x86bcd_pkg::FUNC_DAA, 16'h129A, 1'b0, 1'b0, 8'd10));
        send_word(make_word(x86bcd_pkg::FUNC_DAA, 16'hFFFF, 1'b1, 1'b1, 8'd10));
        send_word(make_word(x86bcd_pkg::FUNC_DAA, 16'h0079, 1'b0, 1'b1, 8'd10));
        send_word(make_word(x86bcd_pkg::FUNC_DAS, 16'h0000, 1'b0, 1'b1, 8'd10));
        send_word(make_word(x86bcd_pkg::FUNC_DAS, 16'h349A, 1'b0, 1'b0, 8'd10));
        send_word(make_word(x86bcd_pkg::FUNC_DAS, 16'h0045, 1'b0, 1'b0, 8'd10));
        send_word(make_word(x86bcd_pkg::FUNC_DAS, 16'hFFFF, 1'b1, 1'b1, 8'd10));
    endtask

    // Unpacked BCD corrections, including carries and borrows that ripple
    // into AH and a sign taken from the top of AX.
    task automatic test_ascii_adjust();
        send_word(make_word(x86bcd_pkg::FUNC_AAA, 16'h0009, 1'b0, 1'b0, 8'd10));
        send_word(make_word(x86bcd_pkg::FUNC_AAA, 16'h00FF, 1'b0, 1'b1, 8'd10));
        send_word(make_word(x86bcd_pkg::FUNC_AAA, 16'hFFFA, 1'b1, 1'b0, 8'd10));
        send_word(make_word(x86bcd_pkg::FUNC_AAS, 16'h0000, 1'b0, 1'b1, 8'd10));
        send_word(make_word(x86bcd_pkg::FUNC_AAS, 16'h8005, 1'b0, 1'b0, 8'd10));
        send_word(make_word(x86bcd_pkg::FUNC_AAS, 16'hFFFF, 1'b1, 1'b1, 8'd10));
    endtask

    // Multiply and divide forms: the usual base ten, base one, the largest
    // base, and AAM with a zero base, which must report a divide error.
    task automatic test_multiply_divide_adjust();
        send_word(make_word(x86bcd_pkg::FUNC_AAM, 16'h00FF, 1'b0, 1'b0, 8'd10));
        send_word(make_word(x86bcd_pkg::FUNC_AAM, 16'h1234, 1'b1, 1'b1, 8'd0));
        send_word(make_word(x86bcd_pkg::FUNC_AAM, 16'hFFFF, 1'b0, 1'b0, 8'hFF));
        send_word(make_word(x86bcd_pkg::FUNC_AAM, 16'h00A7, 1'b0, 1'b0, 8'd1));
        send_word(make_word(x86bcd_pkg::FUNC_AAD, 16'h0909, 1'b0, 1'b0, 8'd10));
        send_word(make_word(x86bcd_pkg::FUNC_AAD, 16'hFFFF, 1'b1, 1'b1, 8'hFF));
        send_word(make_word(x86bcd_pkg::FUNC_AAD, 16'h7F80, 1'b0, 1'b0, 8'd0));
    endtask

    // The spare codes pass AX, CF and AF through and clear the rest.
    task automatic test_unknown_ops();
        send_word(make_word(FUNC_SPARE_6, 16'hA5C3, 1'b1, 1'b0, 8'hFF));
        send_word(make_word(FUNC_SPARE_7, 16'h5A3C, 1'b0, 1'b1, 8'h00));
    endtask

    // Random words, mostly valid instructions. AL is often forced to a legal
    // BCD pair so the corrections see realistic operands, and the base is
    // usually ten with a share of zero and fully random values.
    task automatic test_random_words(input int count);
        x86bcd_pkg::t_in_word w;
        logic [3:0] hi;
        logic [3:0] lo;
        int         pick;
        for (int n = 0; n < count; n++) begin
            // Every two hundred words, set idling on or off at random.
            if (n > 0 && n % 200 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            pick           = $urandom_range(0, 99);
            w.func         = (pick < 4) ? ($urandom_range(0, 1) ? FUNC_SPARE_7 : FUNC_SPARE_6)
                                        : 3'($urandom_range(0, 5));
            w.ax_in        = 16'($urandom);
            w.carry_in     = 1'($urandom_range(0, 1));
            w.aux_carry_in = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 2) == 0) begin
                hi = 4'($urandom_range(0, 9));
                lo = 4'($urandom_range(0, 9));
                w.ax_in[7:0] = {hi, lo};
            end
            pick = $urandom_range(0, 99);
            if (pick < 65)
                w.base_imm = 8'd10;
            else if (pick < 75)
                w.base_imm = 8'd0;
            else
                w.base_imm = 8'($urandom_range(0, 255));
            send_word(w);
        end
    endtask

    // Lets the pipeline run completely dry, then restarts it with a burst
    // in which neither side starts a new bubble or stall.
    task automatic test_pause_until_empty();
        i_valid <= 1'b0;
        wait_until_empty();
        idle_on = 1'b0;
        test_random_words(30);
        idle_on = 1'b1;
    endtask

    initial begin
        words_sent      = 0;
        div_errors_seen = 0;
        idle_on         = 1'b1;
        foreach (func_count[k])
            func_count[k] = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_word  = '0;
        repeat (RESET_TICKS) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_bcd_add_sub_adjust();
        test_ascii_adjust();
        test_multiply_divide_adjust();
        test_unknown_ops();
        test_random_words(500);
        test_pause_until_empty();
        test_random_words(500);

        i_valid <= 1'b0;
        idle_on = 1'b0;
        wait_until_empty();
        repeat (SETTLE) @(negedge i_clk);

        $display("sent %0d words: DAA %0d, DAS %0d, AAA %0d, AAS %0d, AAM %0d, AAD %0d",
                 words_sent,
                 func_count[x86bcd_pkg::FUNC_DAA], func_count[x86bcd_pkg::FUNC_DAS],
                 func_count[x86bcd_pkg::FUNC_AAA], func_count[x86bcd_pkg::FUNC_AAS],
                 func_count[x86bcd_pkg::FUNC_AAM], func_count[x86bcd_pkg::FUNC_AAD]);
        $display("spare codes %0d; checked %0d output words, %0d divide errors, %0d cycles",
                 func_count[FUNC_SPARE_6] + func_count[FUNC_SPARE_7],
                 words_checked, div_errors_seen, cycles);
        if (mismatches == 0 && adjusted_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
